// ===== hdl/nsif_pkg.sv =====
// Shared types, widths and codes of the nearest sector-ID finder.
package nsif_pkg;

   localparam int MAX_SECTORS_DEF = 32;
   localparam logic [15:0] NOT_FOUND_DISTANCE = 16'hFFFF;
   localparam logic [7:0] NONE_BYTE = 8'hFF;

   // Signed width of a wrapped offset: up to 16-bit positions minus a 13-bit head.
   localparam int DIST_W = 18;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_USE_DESCRIPTORS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_BYTES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_INDEX_GAP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_LENGTH = 3'd4;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_FIND = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [4:0]  entry_index;
      logic [12:0] position;
      logic [7:0]  track;
      logic [7:0]  side;
      logic [7:0]  sector_number;
      logic        flag_not_found;
      logic        flag_crc_error;
      logic        any_track;
      logic        any_side;
      logic        any_number;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  sector_order;
      logic [15:0] distance;
      logic [7:0]  match_track;
      logic [7:0]  match_side;
      logic [7:0]  match_number;
   } rsp_type;

   // One stored sector header, 39 bits.
   typedef struct packed {
      logic [12:0] pos;
      logic [7:0]  trk;
      logic [7:0]  sid;
      logic [7:0]  num;
      logic        rnf;
      logic        crc;
   } hdr_type;

   typedef struct packed {
      logic        use_descriptors;
      logic [5:0]  sector_count;
      logic [12:0] track_bytes;
      logic [9:0]  post_index_gap;
      logic [9:0]  record_length;
   } cfg_type;

endpackage

// ===== hdl/nsif_hdr_ram.sv =====
// Sector header table: one write port, one read port with registered read data.
module nsif_hdr_ram
   import nsif_pkg::*;
#(
   parameter int DEPTH = MAX_SECTORS_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  hdr_type           wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output hdr_type           rd_data
);

   hdr_type hdr_mem_ff [DEPTH];
   hdr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/nsif_scan.sv =====
// Command sequencer: header loads and the one-header-per-cycle nearest-match scan.
module nsif_scan
   import nsif_pkg::*;
#(
   parameter int MAX_SECTORS = MAX_SECTORS_DEF,
   localparam int ADDR_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
   localparam int CNT_W = $clog2(MAX_SECTORS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   input  cfg_type           cfg,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output hdr_type           mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  hdr_type           mem_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] eval_idx_ff, eval_idx_in;
   logic [15:0]       std_pos_ff, std_pos_in;
   logic [15:0]       eval_pos_ff, eval_pos_in;
   logic              desc_ff, desc_in;
   logic [12:0]       head_ff, head_in;
   logic [7:0]        qtrk_ff, qtrk_in;
   logic [7:0]        qsid_ff, qsid_in;
   logic [7:0]        qnum_ff, qnum_in;
   logic              any_trk_ff, any_trk_in;
   logic              any_sid_ff, any_sid_in;
   logic              any_num_ff, any_num_in;
   logic              hit_ff, hit_in;
   logic [7:0]        order_ff, order_in;
   logic [15:0]       best_ff, best_in;
   logic [15:0]       last_id_ff, last_id_in;

   logic [7:0]              qnum_eff;
   logic [CNT_W-1:0]        count_eff;
   logic [15:0]             cand_pos;
   logic signed [DIST_W-1:0] d_raw;
   logic signed [DIST_W-1:0] d_wrap;
   logic                    nearer;
   logic                    id_ok;

   assign qnum_eff = req_data.any_number ? NONE_BYTE : req_data.sector_number;
   assign count_eff = (32'(cfg.sector_count) < MAX_SECTORS) ?
                      CNT_W'(cfg.sector_count) : CNT_W'(MAX_SECTORS);

   // Offset ahead of the head, wrapped once by the revolution length.
   assign cand_pos = desc_ff ? {3'b000, mem_rd_data.pos} : eval_pos_ff;
   assign d_raw = $signed({2'b00, cand_pos}) - $signed({5'b00000, head_ff});
   assign d_wrap = d_raw[DIST_W-1] ? d_raw + $signed({5'b00000, cfg.track_bytes}) : d_raw;
   assign nearer = d_wrap < $signed({2'b00, best_ff});
   assign id_ok = !desc_ff || any_trk_ff ||
                  ((mem_rd_data.trk == qtrk_ff) &&
                   (any_sid_ff || (mem_rd_data.sid == qsid_ff)) &&
                   !(mem_rd_data.rnf && mem_rd_data.crc) &&
                   (any_num_ff || (mem_rd_data.num == qnum_ff)));

   assign mem_wr_addr = ADDR_W'(req_data.entry_index);
   assign mem_wr_data = '{pos: req_data.position, trk: req_data.track,
                          sid: req_data.side, num: req_data.sector_number,
                          rnf: req_data.flag_not_found, crc: req_data.flag_crc_error};
   assign mem_rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      rd_vld_in   = 1'b0;
      eval_idx_in = eval_idx_ff;
      std_pos_in  = std_pos_ff;
      eval_pos_in = eval_pos_ff;
      desc_in     = desc_ff;
      head_in     = head_ff;
      qtrk_in     = qtrk_ff;
      qsid_in     = qsid_ff;
      qnum_in     = qnum_ff;
      any_trk_in  = any_trk_ff;
      any_sid_in  = any_sid_ff;
      any_num_in  = any_num_ff;
      hit_in      = hit_ff;
      order_in    = order_ff;
      best_in     = best_ff;
      last_id_in  = last_id_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hit_in  = 1'b0;
               best_in = NOT_FOUND_DISTANCE;
               if (req_data.mode == MODE_LOAD) begin
                  mem_wr_en = 32'(req_data.entry_index) < MAX_SECTORS;
                  order_in  = NONE_BYTE;
                  qnum_in   = 8'd0;
                  state_in  = ST_RESP;
               end else begin
                  desc_in    = cfg.use_descriptors;
                  head_in    = req_data.position;
                  qtrk_in    = req_data.track;
                  qsid_in    = req_data.side;
                  qnum_in    = qnum_eff;
                  any_trk_in = req_data.any_track;
                  any_sid_in = req_data.any_side;
                  any_num_in = req_data.any_number;
                  idx_in     = '0;
                  count_in   = count_eff;
                  std_pos_in = {6'b000000, cfg.post_index_gap};
                  order_in   = cfg.use_descriptors ? NONE_BYTE : qnum_eff - 8'd1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               rd_vld_in   = 1'b1;
               eval_idx_in = idx_ff[ADDR_W-1:0];
               eval_pos_in = std_pos_ff;
               idx_in      = idx_ff + CNT_W'(1);
               std_pos_in  = std_pos_ff + {6'b000000, cfg.record_length};
            end else if (!rd_vld_ff) begin
               state_in = ST_RESP;
            end
            if (rd_vld_ff && nearer && id_ok) begin
               hit_in  = 1'b1;
               best_in = d_wrap[15:0];
               if (desc_ff) begin
                  order_in   = 8'(eval_idx_ff);
                  last_id_in = {mem_rd_data.trk, mem_rd_data.sid};
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         last_id_ff <= 16'd0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         last_id_ff <= last_id_in;
      end
      idx_ff      <= idx_in;
      count_ff    <= count_in;
      eval_idx_ff <= eval_idx_in;
      std_pos_ff  <= std_pos_in;
      eval_pos_ff <= eval_pos_in;
      desc_ff     <= desc_in;
      head_ff     <= head_in;
      qtrk_ff     <= qtrk_in;
      qsid_ff     <= qsid_in;
      qnum_ff     <= qnum_in;
      any_trk_ff  <= any_trk_in;
      any_sid_ff  <= any_sid_in;
      any_num_ff  <= any_num_in;
      hit_ff      <= hit_in;
      order_ff    <= order_in;
      best_ff     <= best_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_strobe = state_ff == ST_RESP;
   assign rsp_data = '{found: hit_ff, sector_order: order_ff, distance: best_ff,
                       match_track: last_id_ff[15:8], match_side: last_id_ff[7:0],
                       match_number: qnum_ff};

endmodule

// ===== hdl/nearest_sector_id_finder.sv =====
// Top level of the nearest sector-ID finder: control registers, header table and scan engine.
//
// A command is taken when start is high while busy is low; busy then stays high until the
// single result has been presented. The result appears on rsp_data for exactly one cycle,
// marked by rsp_strobe, and cannot be held off, so the receiver must take it in that cycle.
// A load command stores one sector header, and its strobe comes in the cycle right after the
// edge that took it. A find command scans the first min(sector_count, MAX_SECTORS) table
// entries through the single read port of the header table, one entry per cycle. After the
// last entry is read, its registered header is evaluated, and the scan then closes before
// the strobe. With an entry count of zero nothing is read. The next command can be taken in
// the cycle after the strobe. Reading a table entry that was never loaded gives an undefined
// header. Control registers are written through the csr_ channel, which is always ready;
// each transfer writes one register, and writes should only be made while busy is low.
module nearest_sector_id_finder
   import nsif_pkg::*;
#(
   parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

   cfg_type cfg_ff, cfg_in;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   hdr_type           mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   hdr_type           mem_rd_data;

   // The register port never stalls; an index outside the register list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_USE_DESCRIPTORS: cfg_in.use_descriptors = csr_data[0];
            CSR_SECTOR_COUNT:    cfg_in.sector_count = csr_data[5:0];
            CSR_TRACK_BYTES:     cfg_in.track_bytes = csr_data[12:0];
            CSR_POST_INDEX_GAP:  cfg_in.post_index_gap = csr_data[9:0];
            CSR_RECORD_LENGTH:   cfg_in.record_length = csr_data[9:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_descriptors: 1'b1, sector_count: 6'd0, track_bytes: 13'd6250,
                     post_index_gap: 10'd60, record_length: 10'd614};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Header table: written by load commands, read once per cycle during a find scan.
   nsif_hdr_ram #(
      .DEPTH(MAX_SECTORS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Command sequencer, match evaluation and result register.
   nsif_scan #(
      .MAX_SECTORS(MAX_SECTORS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

// ===== test/tb_nearest_sector_id_finder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the nearest sector-ID finder: directed table, then random phases.
module tb_nearest_sector_id_finder
   import nsif_pkg::*;
();

   localparam int SLOTS = MAX_SECTORS_DEF;
   // Idle cycles run after the last result before the run ends.
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 130;

   // One line of the directed table: either a register write or a command transfer,
   // optionally with the result typed in by hand.
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      req_type                cmd;
      bit                     has_want;
      rsp_type                want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Our own copy of the block's state and registers, advanced at each accepted transfer.
   hdr_type     sector_headers [SLOTS] = '{default: '0};
   logic [15:0] last_match_id = '0;
   cfg_type     track_cfg = '{1'b1, 6'd0, 13'd6250, 10'd60, 10'd614};

   rsp_type pending_results [$];
   int      mismatch_count = 0;
   int      sender_idle_pct = 0;
   bit      want_pinned = 1'b0;
   rsp_type pinned_result = '0;

   nearest_sector_id_finder DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the result of one command and updates the header table and last match.
   // A negative offset that survives the wrap-around add still wins against any positive
   // one, and the running best is kept as a 16-bit pattern, exactly as the block does.
   function automatic rsp_type predict_sector(input req_type cmd);
      rsp_type     res;
      hdr_type     h;
      int          count;
      int          i;
      int          offset;
      logic [15:0] nearest;
      logic [7:0]  wanted_num;
      logic        hit;
      logic        is_match;
      res = '0;
      if (cmd.mode == MODE_LOAD) begin
         sector_headers[cmd.entry_index] = '{cmd.position, cmd.track, cmd.side,
                                             cmd.sector_number, cmd.flag_not_found,
                                             cmd.flag_crc_error};
         res.sector_order = NONE_BYTE;
         res.distance = NOT_FOUND_DISTANCE;
         res.match_track = last_match_id[15:8];
         res.match_side = last_match_id[7:0];
         return res;
      end
      count = (track_cfg.sector_count < SLOTS) ? int'(track_cfg.sector_count) : SLOTS;
      nearest = NOT_FOUND_DISTANCE;
      res.sector_order = NONE_BYTE;
      hit = 1'b0;
      wanted_num = cmd.any_number ? NONE_BYTE : cmd.sector_number;
      for (i = 0; i < count; i++) begin
         h = sector_headers[i];
         if (track_cfg.use_descriptors) begin
            offset = int'(h.pos) - int'(cmd.position);
         end else begin
            offset = int'(track_cfg.post_index_gap) + int'(track_cfg.record_length) * i
                     - int'(cmd.position);
         end
         if (offset < 0) begin
            offset += int'(track_cfg.track_bytes);
         end
         if (offset < int'(nearest)) begin
            // Headers with both error flags are skipped only when the track is compared.
            is_match = !track_cfg.use_descriptors || cmd.any_track
                       || (h.trk == cmd.track && (cmd.any_side || h.sid == cmd.side)
                           && !(h.rnf && h.crc) && (cmd.any_number || h.num == wanted_num));
            if (is_match) begin
               hit = 1'b1;
               nearest = 16'(offset);
               if (track_cfg.use_descriptors) begin
                  res.sector_order = 8'(i);
                  last_match_id = {h.trk, h.sid};
               end
            end
         end
      end
      // The standard layout reports the wanted number minus one, hit or not.
      if (!track_cfg.use_descriptors) begin
         res.sector_order = wanted_num - 8'd1;
      end
      res.found = hit;
      res.distance = nearest;
      res.match_track = last_match_id[15:8];
      res.match_side = last_match_id[7:0];
      res.match_number = wanted_num;
      return res;
   endfunction

   task automatic report_mismatch(input string line);
      $display("[%0t] ERROR: %s", $time, line);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   // Everything is sampled at the rising edge, while the inputs driven at the falling edge
   // are stable: register writes, command transfers and result strobes.
   always @(posedge clock) begin : transfer_monitor
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_USE_DESCRIPTORS: track_cfg.use_descriptors = csr_data[0];
               CSR_SECTOR_COUNT:    track_cfg.sector_count = csr_data[5:0];
               CSR_TRACK_BYTES:     track_cfg.track_bytes = csr_data[12:0];
               CSR_POST_INDEX_GAP:  track_cfg.post_index_gap = csr_data[9:0];
               CSR_RECORD_LENGTH:   track_cfg.record_length = csr_data[9:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            // The predictor always runs so that the table stays current, even when the
            // row carries a hand-typed result.
            predicted = predict_sector(req_data);
            pending_results.push_back(want_pinned ? pinned_result : predicted);
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result %h arrived with nothing pending", rsp_data));
            end else begin
               want = pending_results.pop_front();
               check_field("found", 16'(rsp_data.found), 16'(want.found));
               check_field("sector_order", 16'(rsp_data.sector_order),
                           16'(want.sector_order));
               check_field("distance", rsp_data.distance, want.distance);
               check_field("match_track", 16'(rsp_data.match_track), 16'(want.match_track));
               check_field("match_side", 16'(rsp_data.match_side), 16'(want.match_side));
               check_field("match_number", 16'(rsp_data.match_number),
                           16'(want.match_number));
            end
         end
      end
   end

   // Presents one command, idling first at the current rate, and returns at the falling
   // edge after its transfer. Start stays high so a following command keeps it raised.
   task automatic send_item(input req_type cmd, input bit has_want, input rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = cmd;
      want_pinned = has_want;
      pinned_result = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Every command has exactly one result, so an empty queue and a low busy mean idle.
   task automatic wait_until_idle();
      start = 1'b0;
      while (pending_results.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Picks a new track geometry, leaning on the extremes of each register.
   task automatic randomize_track();
      logic [CSR_DATA_W-1:0] count;
      logic [CSR_DATA_W-1:0] bytes;
      logic [CSR_DATA_W-1:0] gap;
      logic [CSR_DATA_W-1:0] rec;
      case ($urandom_range(7))
         0: count = '0;
         1: count = CSR_DATA_W'(1);
         2: count = CSR_DATA_W'(SLOTS);
         3: count = CSR_DATA_W'($urandom_range(63, SLOTS + 1));
         default: count = CSR_DATA_W'($urandom_range(SLOTS - 1, 2));
      endcase
      case ($urandom_range(6))
         0: bytes = '0;
         1: bytes = CSR_DATA_W'(1);
         2: bytes = CSR_DATA_W'(8191);
         3: bytes = CSR_DATA_W'(6250);
         default: bytes = CSR_DATA_W'($urandom_range(8191, 1));
      endcase
      case ($urandom_range(4))
         0: gap = '0;
         1: gap = CSR_DATA_W'(1023);
         default: gap = CSR_DATA_W'($urandom_range(1023));
      endcase
      case ($urandom_range(5))
         0: rec = '0;
         1: rec = CSR_DATA_W'(1);
         2: rec = CSR_DATA_W'(1023);
         default: rec = CSR_DATA_W'($urandom_range(1023, 1));
      endcase
      write_csr(CSR_USE_DESCRIPTORS, CSR_DATA_W'($urandom_range(3) != 0));
      write_csr(CSR_SECTOR_COUNT, count);
      write_csr(CSR_TRACK_BYTES, bytes);
      write_csr(CSR_POST_INDEX_GAP, gap);
      write_csr(CSR_RECORD_LENGTH, rec);
   endtask

   // Most loads draw from a small pool of IDs and most finds ask for a header that is in
   // the table, so that matches, ties and skipped headers are common; the rest is noise.
   function automatic req_type random_request();
      req_type     cmd;
      hdr_type     h;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      cmd = noise[47:0];
      h = sector_headers[$urandom_range(SLOTS - 1)];
      if ($urandom_range(99) < 40) begin
         cmd.mode = MODE_LOAD;
         if ($urandom_range(3) != 0) begin
            cmd.track = 8'($urandom_range(3));
            cmd.side = 8'($urandom_range(1));
            cmd.sector_number = 8'($urandom_range(8, 1));
         end
         if (track_cfg.track_bytes != 0 && $urandom_range(1) != 0) begin
            cmd.position = 13'($urandom_range(track_cfg.track_bytes - 1));
         end
      end else begin
         cmd.mode = MODE_FIND;
         if ($urandom_range(3) != 0) begin
            cmd.track = h.trk;
            cmd.side = h.sid;
            cmd.sector_number = h.num;
         end
         if ($urandom_range(3) == 0) begin
            cmd.position = h.pos;
         end
         cmd.any_track = ($urandom_range(7) == 0);
         cmd.any_side = ($urandom_range(3) == 0);
         cmd.any_number = ($urandom_range(3) == 0);
      end
      return cmd;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   function automatic stim_row_type load_row(input logic [4:0] slot, input logic [12:0] pos,
                                             input logic [7:0] trk, input logic [7:0] sid,
                                             input logic [7:0] num, input logic rnf,
                                             input logic crc);
      stim_row_type r;
      r = '{default: '0};
      r.cmd.mode = MODE_LOAD;
      r.cmd.entry_index = slot;
      r.cmd.position = pos;
      r.cmd.track = trk;
      r.cmd.side = sid;
      r.cmd.sector_number = num;
      r.cmd.flag_not_found = rnf;
      r.cmd.flag_crc_error = crc;
      return r;
   endfunction

   function automatic stim_row_type find_row(input logic [12:0] pos, input logic [7:0] trk,
                                             input logic [7:0] sid, input logic [7:0] num,
                                             input logic any_t, input logic any_s,
                                             input logic any_n);
      stim_row_type r;
      r = '{default: '0};
      r.cmd.mode = MODE_FIND;
      r.cmd.position = pos;
      r.cmd.track = trk;
      r.cmd.side = sid;
      r.cmd.sector_number = num;
      r.cmd.any_track = any_t;
      r.cmd.any_side = any_s;
      r.cmd.any_number = any_n;
      return r;
   endfunction

   function automatic stim_row_type pin(input stim_row_type r, input rsp_type want);
      stim_row_type p;
      p = r;
      p.has_want = 1'b1;
      p.want = want;
      return p;
   endfunction

   // Result of anything that finds no header while the last match is still clear.
   function automatic rsp_type idle_answer(input logic [7:0] num);
      return '{1'b0, NONE_BYTE, NOT_FOUND_DISTANCE, 8'h00, 8'h00, num};
   endfunction

   initial begin : stimulus
      stim_row_type directed [$];
      req_type      cmd;
      int           p;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // After reset no header is on the track, so nothing can be found.
      directed.push_back(pin(find_row(13'd0, 8'h12, 8'h34, 8'h12, 1'b0, 1'b0, 1'b0),
                             idle_answer(8'h12)));
      directed.push_back(pin(find_row(13'd8191, 8'hFF, 8'hFF, 8'h56, 1'b1, 1'b1, 1'b1),
                             idle_answer(NONE_BYTE)));
      // Loads echo the still clear last match.
      directed.push_back(pin(load_row(5'd0, 13'd8191, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1),
                             idle_answer(8'h00)));
      directed.push_back(pin(load_row(5'd1, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0),
                             idle_answer(8'h00)));
      directed.push_back(pin(load_row(5'd2, 13'd100, 8'h05, 8'h01, 8'h03, 1'b1, 1'b0),
                             idle_answer(8'h00)));
      directed.push_back(pin(load_row(5'd3, 13'd100, 8'h05, 8'h01, 8'h03, 1'b0, 1'b1),
                             idle_answer(8'h00)));
      directed.push_back(csr_row(CSR_SECTOR_COUNT, 13'd4));
      // Two equally near headers: the lower slot wins.
      directed.push_back(find_row(13'd50, 8'h05, 8'h01, 8'h03, 1'b0, 1'b0, 1'b0));
      // The only candidate carries both error flags and is skipped.
      directed.push_back(find_row(13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
      // Any track matches every header, the flagged one included.
      directed.push_back(find_row(13'd8000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
      directed.push_back(find_row(13'd101, 8'h00, 8'h09, 8'h09, 1'b0, 1'b1, 1'b1));
      directed.push_back(load_row(5'd3, 13'd4095, 8'h05, 8'h02, 8'h03, 1'b1, 1'b1));
      // With no revolution length the offset behind the head stays negative.
      directed.push_back(csr_row(CSR_TRACK_BYTES, 13'd0));
      directed.push_back(find_row(13'd8191, 8'h05, 8'h01, 8'h03, 1'b0, 1'b0, 1'b0));
      directed.push_back(csr_row(CSR_TRACK_BYTES, 13'd1));
      directed.push_back(find_row(13'd4096, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
      directed.push_back(csr_row(CSR_TRACK_BYTES, 13'd8191));
      directed.push_back(find_row(13'd8191, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
      // Standard layout with an oversized sector count and the widest spacing.
      directed.push_back(csr_row(CSR_USE_DESCRIPTORS, 13'd0));
      directed.push_back(csr_row(CSR_SECTOR_COUNT, 13'd63));
      directed.push_back(csr_row(CSR_POST_INDEX_GAP, 13'd1023));
      directed.push_back(csr_row(CSR_RECORD_LENGTH, 13'd1023));
      directed.push_back(find_row(13'd1023, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
      directed.push_back(find_row(13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
      directed.push_back(csr_row(CSR_POST_INDEX_GAP, 13'd0));
      directed.push_back(csr_row(CSR_RECORD_LENGTH, 13'd0));
      directed.push_back(find_row(13'd8191, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0));
      directed.push_back(csr_row(CSR_RECORD_LENGTH, 13'd1));
      directed.push_back(find_row(13'd0, 8'h00, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0));

      foreach (directed[k]) begin
         if (directed[k].is_csr) begin
            wait_until_idle();
            write_csr(directed[k].reg_index, directed[k].reg_value);
         end else begin
            send_item(directed[k].cmd, directed[k].has_want, directed[k].want);
         end
      end

      // Fill every slot so that no later scan can touch a header that was never loaded.
      for (p = 0; p < SLOTS; p++) begin
         cmd = random_request();
         cmd.mode = MODE_LOAD;
         cmd.entry_index = 5'(p);
         send_item(cmd, 1'b0, '0);
      end

      // Random phases, each on a fresh geometry, cycling through the sender idle rates.
      for (p = 0; p < PHASES; p++) begin
         wait_until_idle();
         randomize_track();
         sender_idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 64 : 36);
         repeat (ITEMS_PER_PHASE) send_item(random_request(), 1'b0, '0);
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // A hung handshake ends the run here; even with every find scanning 32 headers a correct
   // run needs only a small part of this.
   initial begin : watchdog
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
